[sv/double_ended_queue_unit_macros.svh]
// Assertion helpers for the deque checker.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

// Plain property under the block clock, masked while in reset.
`define DEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define DEQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define DEQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/deq_pkg.sv]
package deq_pkg;

  localparam int DEPTH = 16;

  localparam int WORD_W  = 32;
  localparam int CNT_W   = 5;
  localparam int MODE_W  = 3;
  localparam int STAT_W  = 2;

  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_QUERY      = 3'd4;

  localparam logic [STAT_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

  // -12345, read out at both ends of an empty deque
  localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd12345;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic shift_back;  // push front: everything moves one cell back
    logic shift_front; // pop front: everything moves one cell forward
    logic load_back;   // push back: first free cell takes the word
    logic drop_back;   // pop back: last occupied cell frees itself
  } cell_cmd_t;

endpackage

[sv/deq_cell.sv]
module deq_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  deq_pkg::cell_cmd_t                  cmd,
  input  logic signed [deq_pkg::WORD_W-1:0]   push_value,
  input  logic signed [deq_pkg::WORD_W-1:0]   left_data,
  input  logic                                left_occ,
  input  logic signed [deq_pkg::WORD_W-1:0]   right_data,
  input  logic                                right_occ,
  output logic signed [deq_pkg::WORD_W-1:0]   data_q,
  output logic                                occ_q
);

  logic signed [deq_pkg::WORD_W-1:0] data_r, data_nxt;
  logic                              occ_r, occ_nxt;

  always_comb begin
    data_nxt = data_r;
    occ_nxt  = occ_r;
    if (cmd.shift_back) begin
      data_nxt = left_data;
      occ_nxt  = left_occ;
    end else if (cmd.shift_front) begin
      data_nxt = right_data;
      occ_nxt  = right_occ;
    end else if (cmd.load_back && !occ_r && left_occ) begin
      data_nxt = push_value;
      occ_nxt  = 1'b1;
    end else if (cmd.drop_back && occ_r && !right_occ) begin
      occ_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  assign data_q = data_r;
  assign occ_q  = occ_r;

endmodule

[sv/double_ended_queue_unit.sv]
// Channel  Dir  Handshake            Payload ports                               Moves
// in       in   in_valid/in_ready    in_mode, in_push_value                      one request
// out      out  out_valid/out_ready  out_front/back_value, out_entry_count/status one result
//
// One request per cycle. A request is applied to the cell row at its accept edge;
// its result shows on the out ports in the next cycle, straight from the cells.
// in_ready is high when no result is pending or the pending one is taken in the
// same cycle, so back-to-back requests flow at one per clock when out_ready holds.
// A stalled result holds the cell row, and with it the input, until out_ready.
// Reset (rst_n low at a clock edge) empties the deque; cell data is not cleared.
module double_ended_queue_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [deq_pkg::MODE_W-1:0]          in_mode,
  input  logic signed [deq_pkg::WORD_W-1:0]   in_push_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [deq_pkg::WORD_W-1:0]   out_front_value,
  output logic signed [deq_pkg::WORD_W-1:0]   out_back_value,
  output logic [deq_pkg::CNT_W-1:0]           out_entry_count,
  output logic [deq_pkg::STAT_W-1:0]          out_status
);

  localparam int D = deq_pkg::DEPTH;

  // Cell row: cell 0 is the front; occupied cells form a prefix (thermometer).
  logic signed [deq_pkg::WORD_W-1:0] cell_data [D];
  logic [D-1:0]                      cell_occ;
  logic signed [deq_pkg::WORD_W-1:0] left_data [D];
  logic [D-1:0]                      left_occ;
  logic signed [deq_pkg::WORD_W-1:0] right_data [D];
  logic [D-1:0]                      right_occ;

  deq_pkg::cell_cmd_t cmd;

  logic                       out_valid_r, out_valid_nxt;
  logic [deq_pkg::STAT_W-1:0] status_r, status_nxt;
  logic [deq_pkg::CNT_W-1:0]  count_r, count_nxt;   // occupancy mod 32

  logic accept;
  logic full, empty;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Full when the last cell holds a word, empty when the first one is free.
  assign full  = cell_occ[D-1];
  assign empty = !cell_occ[0];

  // Decode the request into a cell command, status and count update.
  always_comb begin
    cmd        = '0;
    status_nxt = status_r;
    count_nxt  = count_r;
    if (accept) begin
      status_nxt = deq_pkg::STATUS_DONE;
      case (in_mode)
        deq_pkg::MODE_PUSH_FRONT, deq_pkg::MODE_PUSH_BACK: begin
          if (full) begin
            status_nxt = deq_pkg::STATUS_FULL;
          end else begin
            cmd.shift_back = (in_mode == deq_pkg::MODE_PUSH_FRONT);
            cmd.load_back  = (in_mode == deq_pkg::MODE_PUSH_BACK);
            count_nxt      = count_r + deq_pkg::CNT_W'(1);
          end
        end
        deq_pkg::MODE_POP_FRONT, deq_pkg::MODE_POP_BACK: begin
          if (empty) begin
            status_nxt = deq_pkg::STATUS_EMPTY;
          end else begin
            cmd.shift_front = (in_mode == deq_pkg::MODE_POP_FRONT);
            cmd.drop_back   = (in_mode == deq_pkg::MODE_POP_BACK);
            count_nxt       = count_r - deq_pkg::CNT_W'(1);
          end
        end
        // query, and the unused codes that behave as query
        default: begin
        end
      endcase
    end
  end

  // Neighbor wiring; the ends see the incoming word and an empty cell.
  always_comb begin
    for (int i = 0; i < D; i++) begin
      if (i == 0) begin
        left_data[i] = in_push_value;
        left_occ[i]  = 1'b1;
      end else begin
        left_data[i] = cell_data[i-1];
        left_occ[i]  = cell_occ[i-1];
      end
      if (i == D-1) begin
        right_data[i] = '0;
        right_occ[i]  = 1'b0;
      end else begin
        right_data[i] = cell_data[i+1];
        right_occ[i]  = cell_occ[i+1];
      end
    end
  end

  for (genvar g = 0; g < D; g++) begin : g_cell
    deq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .push_value (in_push_value),
      .left_data  (left_data[g]),
      .left_occ   (left_occ[g]),
      .right_data (right_data[g]),
      .right_occ  (right_occ[g]),
      .data_q     (cell_data[g]),
      .occ_q      (cell_occ[g])
    );
  end

  // Back entry: the one occupied cell whose right neighbor is free.
  // One-hot AND-OR select across the row.
  logic signed [deq_pkg::WORD_W-1:0] back_sel;
  always_comb begin
    back_sel = '0;
    for (int i = 0; i < D; i++) begin
      if (cell_occ[i] && !right_occ[i]) begin
        back_sel = back_sel | cell_data[i];
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      status_r    <= deq_pkg::STATUS_DONE;
      count_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
      count_r     <= count_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_front_value = empty ? deq_pkg::EMPTY_WORD : cell_data[0];
  assign out_back_value  = empty ? deq_pkg::EMPTY_WORD : back_sel;
  assign out_entry_count = count_r;
  assign out_status      = status_r;

endmodule

[sv/deq_checker.sv]
`include "double_ended_queue_unit_macros.svh"

module deq_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [deq_pkg::WORD_W-1:0]   out_front_value,
  input logic signed [deq_pkg::WORD_W-1:0]   out_back_value,
  input logic [deq_pkg::CNT_W-1:0]           out_entry_count,
  input logic [deq_pkg::STAT_W-1:0]          out_status
);

  `DEQ_ASSERT_IMP(a_full_count, out_valid && out_status == deq_pkg::STATUS_FULL, out_entry_count == deq_pkg::CNT_W'(deq_pkg::DEPTH), "full reject with count below depth")
  `DEQ_ASSERT_IMP(a_empty_ends, out_valid && out_entry_count == '0, out_front_value == deq_pkg::EMPTY_WORD && out_back_value == deq_pkg::EMPTY_WORD, "empty deque shows a stored word")
  `DEQ_ASSERT_IMP(a_empty_pop, out_valid && out_status == deq_pkg::STATUS_EMPTY, out_entry_count == '0, "empty pop flagged with entries held")
  `DEQ_ASSERT(a_status_code, !out_valid || out_status == deq_pkg::STATUS_DONE || out_status == deq_pkg::STATUS_FULL || out_status == deq_pkg::STATUS_EMPTY, "undefined status code")
  `DEQ_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_front_value) && $stable(out_back_value) && $stable(out_entry_count) && $stable(out_status), "stalled result changed")

endmodule

bind double_ended_queue_unit deq_checker u_deq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_front_value (out_front_value),
  .out_back_value  (out_back_value),
  .out_entry_count (out_entry_count),
  .out_status      (out_status)
);

[verif/tb_double_ended_queue_unit.sv]
`timescale 1ns / 100ps

// Deque unit testbench.
// A queue of requests is built up front: a short directed set, then bursts
// that lean toward filling, draining or mixing, so that full and empty are
// hit often. A clocked driver feeds the requests with random gaps. A clocked
// monitor checks every result against a shadow ring, updated when the
// request is accepted.
module tb_double_ended_queue_unit;

  localparam int RANDOM_REQUESTS = 400;
  localparam int WATCHDOG_LIMIT  = 2000; // idle cycles with no handshake on either side
  localparam int SETTLE_CYCLES   = 8;    // spare cycles after the last result is checked

  typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIXED} burst_kind_t;

  // One pending request plus its pacing.
  typedef struct {
    logic [deq_pkg::MODE_W-1:0]        mode;
    logic signed [deq_pkg::WORD_W-1:0] word;
    int unsigned                       gap;         // idle cycles before it is offered
    logic                              drain_first; // hold it back until all results are in
  } request_t;

  // Ends and count of the deque after one request.
  typedef struct {
    logic signed [deq_pkg::WORD_W-1:0] front;
    logic signed [deq_pkg::WORD_W-1:0] back;
    logic [deq_pkg::CNT_W-1:0]         count;
    logic [deq_pkg::STAT_W-1:0]        status;
  } deque_view_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic [deq_pkg::MODE_W-1:0]         in_mode = '0;
  logic signed [deq_pkg::WORD_W-1:0]  in_push_value = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic signed [deq_pkg::WORD_W-1:0]  out_front_value;
  logic signed [deq_pkg::WORD_W-1:0]  out_back_value;
  logic [deq_pkg::CNT_W-1:0]          out_entry_count;
  logic [deq_pkg::STAT_W-1:0]         out_status;

  request_t    pending[$];
  deque_view_t expected_views[$];

  // Shadow of the ring: contents, front position, number held.
  logic signed [deq_pkg::WORD_W-1:0] shadow_ring [deq_pkg::DEPTH];
  int unsigned                       shadow_head = 0;
  int unsigned                       shadow_held = 0;

  logic        live = 1'b0;      // reset seen released at a clock edge
  logic        req_taken = 1'b0; // request accepted at the last rising edge
  int unsigned ready_hold = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  logic        calm;

  double_ended_queue_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_push_value   (in_push_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value),
    .out_entry_count (out_entry_count),
    .out_status      (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // For a quarter of the time the receiver starts no new stall.
  assign calm = (cycle_count % 256) < 64;

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Random word, with the extremes and the empty marker mixed in.
  function automatic logic signed [deq_pkg::WORD_W-1:0] pick_word();
    case ($urandom_range(0, 19))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return '1;
      4:       return deq_pkg::EMPTY_WORD;
      default: return $urandom;
    endcase
  endfunction

  // Shadow update for one accepted request; returns what the block should show.
  function automatic deque_view_t apply_request(
      input logic [deq_pkg::MODE_W-1:0] mode,
      input logic signed [deq_pkg::WORD_W-1:0] word);
    deque_view_t v;
    v.status = deq_pkg::STATUS_DONE;
    v.front  = deq_pkg::EMPTY_WORD;
    v.back   = deq_pkg::EMPTY_WORD;
    case (mode)
      deq_pkg::MODE_PUSH_FRONT, deq_pkg::MODE_PUSH_BACK: begin
        if (shadow_held >= deq_pkg::DEPTH) begin
          v.status = deq_pkg::STATUS_FULL;
        end else if (mode == deq_pkg::MODE_PUSH_FRONT) begin
          shadow_head = (shadow_head + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH;
          shadow_ring[shadow_head] = word;
          shadow_held++;
        end else begin
          shadow_ring[(shadow_head + shadow_held) % deq_pkg::DEPTH] = word;
          shadow_held++;
        end
      end
      deq_pkg::MODE_POP_FRONT, deq_pkg::MODE_POP_BACK: begin
        if (shadow_held == 0) begin
          v.status = deq_pkg::STATUS_EMPTY;
        end else begin
          if (mode == deq_pkg::MODE_POP_FRONT) shadow_head = (shadow_head + 1) % deq_pkg::DEPTH;
          shadow_held--;
        end
      end
      default: ; // query, and the unused codes behave the same
    endcase
    if (shadow_held != 0) begin
      v.front = shadow_ring[shadow_head];
      v.back  = shadow_ring[(shadow_head + shadow_held - 1) % deq_pkg::DEPTH];
    end
    v.count = deq_pkg::CNT_W'(shadow_held);
    return v;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] result %0d: %0s", $realtime, results_seen, what);
  endtask

  task automatic add_request(input logic [deq_pkg::MODE_W-1:0] mode,
                             input logic signed [deq_pkg::WORD_W-1:0] word,
                             input int unsigned gap, input logic drain_first);
    request_t r;
    r.mode        = mode;
    r.word        = word;
    r.gap         = gap;
    r.drain_first = drain_first;
    pending.push_back(r);
  endtask

  // Stimulus, reset, and end of run.
  initial begin
    int unsigned                 made;
    int unsigned                 burst_len;
    int unsigned                 push_pct;
    burst_kind_t                 kind;
    logic                        quiet;
    logic                        drain;
    logic [deq_pkg::MODE_W-1:0]  mode;

    // Directed: both flagged cases on an empty deque, an unused code.
    add_request(deq_pkg::MODE_QUERY, 32'sh1234_5678, 0, 1'b0);
    add_request(deq_pkg::MODE_POP_FRONT, '1, 0, 1'b0);
    add_request(deq_pkg::MODE_POP_BACK, '0, 0, 1'b0);
    add_request(3'd7, 32'sh7FFF_FFFF, 0, 1'b0);
    // Fill from both ends so the front wraps below slot zero.
    for (int i = 0; i < deq_pkg::DEPTH; i++) begin
      mode = (i % 2 == 0) ? deq_pkg::MODE_PUSH_FRONT : deq_pkg::MODE_PUSH_BACK;
      case (i)
        0:       add_request(mode, 32'sh7FFF_FFFF, 0, 1'b0);
        1:       add_request(mode, 32'sh8000_0000, 0, 1'b0);
        2:       add_request(mode, '1, 0, 1'b0);
        3:       add_request(mode, '0, 0, 1'b0);
        4:       add_request(mode, deq_pkg::EMPTY_WORD, 0, 1'b0);
        default: add_request(mode, $urandom, 0, 1'b0);
      endcase
    end
    // Full: both pushes rejected, then a pop at each end.
    add_request(deq_pkg::MODE_PUSH_FRONT, 32'sh5555_5555, 0, 1'b0);
    add_request(deq_pkg::MODE_PUSH_BACK, 32'shAAAA_AAAA, 0, 1'b0);
    add_request(deq_pkg::MODE_POP_FRONT, '0, 0, 1'b0);
    add_request(deq_pkg::MODE_POP_BACK, '0, 0, 1'b0);

    // Random bursts. Fill and drain bursts push the deque to its limits.
    made = 0;
    while (made < RANDOM_REQUESTS) begin
      kind      = burst_kind_t'($urandom_range(0, 2));
      burst_len = $urandom_range(8, 40);
      quiet     = ($urandom_range(0, 3) == 0);
      drain     = (made == 0) || ($urandom_range(0, 3) == 0);
      push_pct  = (kind == BURST_FILL) ? 80 : (kind == BURST_DRAIN) ? 20 : 50;
      for (int k = 0; k < burst_len; k++) begin
        if ($urandom_range(0, 99) < 10) begin
          mode = deq_pkg::MODE_W'($urandom_range(0, 7)); // noise: any code, unused ones too
        end else if ($urandom_range(0, 99) < push_pct) begin
          mode = $urandom_range(0, 1) ? deq_pkg::MODE_PUSH_BACK : deq_pkg::MODE_PUSH_FRONT;
        end else begin
          mode = $urandom_range(0, 1) ? deq_pkg::MODE_POP_BACK : deq_pkg::MODE_POP_FRONT;
        end
        add_request(mode, pick_word(), quiet ? 0 : pick_gap(), drain && (k == 0));
        made++;
      end
    end

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || in_valid || expected_views.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("double_ended_queue_unit: match");
    end else begin
      $display("double_ended_queue_unit: mismatch");
    end
    $finish;
  end

  always @(posedge clk) begin
    live        <= rst_n;
    cycle_count <= cycle_count + 1;
  end

  // Accept side: note the handshake and predict the result.
  always @(posedge clk) begin
    req_taken <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) expected_views.push_back(apply_request(in_mode, in_push_value));
  end

  // Request driver. A request on the port is held until taken; the next
  // one waits out its gap, and a drain-marked one waits for an empty scoreboard.
  always @(negedge clk) begin : drive_requests
    request_t nxt;
    if (live && !(in_valid && !req_taken)) begin
      if (pending.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        nxt = pending[0];
        if (nxt.drain_first && expected_views.size() != 0) begin
          in_valid <= 1'b0;
        end else if (nxt.gap != 0) begin
          nxt.drain_first = 1'b0;
          nxt.gap--;
          pending[0] = nxt;
          in_valid <= 1'b0;
        end else begin
          void'(pending.pop_front());
          in_valid      <= 1'b1;
          in_mode       <= nxt.mode;
          in_push_value <= nxt.word;
        end
      end
    end
  end

  // Result receiver back-pressure.
  always @(negedge clk) begin
    if (!live) begin
      out_ready <= 1'b0;
    end else if (ready_hold != 0) begin
      out_ready  <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else begin
      out_ready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) ready_hold <= pick_gap();
    end
  end

  // Monitor: each result against the oldest prediction.
  always @(posedge clk) begin : check_results
    deque_view_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_views.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = expected_views.pop_front();
        if (out_front_value !== want.front)
          report_mismatch($sformatf("front_value got %0d want %0d", out_front_value, want.front));
        if (out_back_value !== want.back)
          report_mismatch($sformatf("back_value got %0d want %0d", out_back_value, want.back));
        if (out_entry_count !== want.count)
          report_mismatch($sformatf("entry_count got %0d want %0d", out_entry_count, want.count));
        if (out_status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", out_status, want.status));
      end
    end
  end

  // Watchdog: too long without any handshake means the block hung.
  always @(posedge clk) begin
    if (!live || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("double_ended_queue_unit: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

[filelist.f]
+incdir+sv
sv/deq_pkg.sv
sv/deq_cell.sv
sv/double_ended_queue_unit.sv
sv/deq_checker.sv
verif/tb_double_ended_queue_unit.sv
